// ===== src/sha512_hash_core_unit_defines.svh =====
// assertion macros for the sha-512 core
`ifndef SHA512_HASH_CORE_UNIT_DEFINES_SVH
`define SHA512_HASH_CORE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// sha512_pkg
// constants and round functions shared by the sha-512 core
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int unsigned RoundCountDefault = 80;
    localparam int unsigned MaxRounds         = 80;

    typedef logic [63:0] t_word;

    // round constants
    localparam t_word RoundConst [MaxRounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // initial hash values
    localparam t_word InitHash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // handshake between sequencer and round unit
    typedef struct packed {
        logic start;   // load working vars and begin a block
    } t_rnd_ctrl;

    typedef struct packed {
        logic done;    // hash state updated, block finished
    } t_rnd_stat;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== src/sha512_hash_core_unit.sv =====
// ----------------------------------------------------------------------------
// sha512_hash_core_unit
// sha-512 core: word intake with padding, shared round unit, digest output
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata = data_word, tuser = valid_bytes, tlast = last_word.
// Words are collected into a 16-word block, at most one transaction per cycle.
// After the sixteenth word tready stays low while the single shared round
// unit compresses the block (start, one round per cycle, add-back, handoff).
// On the last word the intake appends the padding bit, zeros and the length,
// one padding word per cycle, and compresses one or two more blocks. Once the
// final block is compressed, eight digest words leave on m_axis (tdata =
// digest_word, tlast = digest_last), one per transaction; a stalled receiver
// holds the current word and the intake stays closed. After the eighth word
// the intake reopens on the next cycle and the hash state returns to its
// initial value. Synchronous active-low reset clears all control state and
// loads the initial hash; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha512_hash_core_unit
    import sha512_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = RoundCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_word
    input  logic [3:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // digest_last
);

    `include "sha512_hash_core_unit_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_WAIT, S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_blk [16];
    logic [3:0]  r_pos;
    t_word       r_len;
    logic        r_pad_len;    // one-bit padding word still owed
    logic        r_len_slot;   // word 14 is padding: length fits in word 15
    logic        r_final;      // the block in flight ends the message
    logic        r_in_msg_end; // message ended, padding not finished
    logic [2:0]  r_oidx;
    logic        r_start;
    logic        r_init;
    t_rnd_ctrl   ctrl;
    t_rnd_stat   stat;
    t_word       hash [8];

    logic [3:0]  nb;
    t_word       kept, pword;
    logic        take;

    assign ctrl.start = r_start;

    sha512_round #(.ROUND_COUNT(ROUND_COUNT)) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_init  (r_init),
        .i_blk   (r_blk),
        .o_stat  (stat),
        .o_hash  (hash)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_start;
    assign take          = s_axis_tvalid && s_axis_tready;

    // last-word masking and padding bit
    always_comb begin
        nb = (!s_axis_tlast || s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
        kept  = s_axis_tdata & ~({64{1'b1}} >> {nb[3:0], 3'b000});
        pword = kept | ((nb == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {nb[2:0], 3'b000})));
    end

    // intake, padding and output sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_len      <= '0;
            r_pad_len  <= 1'b0;
            r_len_slot <= 1'b0;
            r_final    <= 1'b0;
            r_oidx     <= '0;
            r_start    <= 1'b0;
            r_init     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_start <= take && (r_pos == 4'd15);
                    r_init  <= 1'b0;
                    if (take) begin
                        r_len        <= r_len + {57'd0, nb, 3'd0};
                        r_blk[r_pos] <= pword;
                        r_pos        <= r_pos + 4'd1;
                        r_pad_len    <= (nb == 4'd8);
                        // a full block is compressed first, padding follows
                        if (r_pos == 4'd15) r_state <= S_WAIT;
                        else if (s_axis_tlast) r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_start <= (r_pos == 4'd15);
                    r_init  <= 1'b0;
                    // padding words, one per cycle
                    if (r_pos == 4'd0 && r_final) begin
                        r_state <= S_OUT;
                    end else if (r_pad_len) begin
                        r_blk[r_pos] <= 64'h8000000000000000;
                        r_pad_len    <= 1'b0;
                        r_pos        <= r_pos + 4'd1;
                        if (r_pos == 4'd15) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_blk[r_pos] <= (r_pos == 4'd15 && r_len_slot) ? r_len : 64'd0;
                        r_pos        <= r_pos + 4'd1;
                        if (r_pos == 4'd14) r_len_slot <= 1'b1;
                        if (r_pos == 4'd15) begin
                            r_len_slot <= 1'b0;
                            r_final    <= r_len_slot;
                            r_state    <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    r_start <= 1'b0;
                    r_init  <= 1'b0;
                    if (stat.done) begin
                        r_state <= r_final ? S_OUT : (r_in_msg_end ? S_PAD : S_IDLE);
                    end
                end
                S_OUT: begin
                    r_start <= 1'b0;
                    r_init  <= m_axis_tready && (r_oidx == 3'd7);
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_len   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_start <= 1'b0;
                    r_init  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // padding in progress: message ended but length block not yet sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_msg_end <= 1'b0;
        else if (take && s_axis_tlast) r_in_msg_end <= 1'b1;
        else if (r_state == S_OUT) r_in_msg_end <= 1'b0;
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = hash[r_oidx];
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // checks
    `SHA_ASSERT_IMPL(a_no_ready_out, m_axis_tvalid, !s_axis_tready,
        "input ready while digest is shown")
    `SHA_ASSERT_NEXT(a_start_waits, r_start, r_state == S_WAIT,
        "block start not followed by wait")
    `SHA_ASSERT_IMPL(a_last_idx, m_axis_tvalid && m_axis_tlast, r_oidx == 3'd7,
        "tlast off the eighth word")

endmodule

// ===== src/sha512_round.sv =====
// ----------------------------------------------------------------------------
// sha512_round
// one compression round per cycle over a 16-word rolling schedule window
// ----------------------------------------------------------------------------
module sha512_round
    import sha512_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = RoundCountDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rnd_ctrl i_ctrl,
    input  logic      i_init,       // restore initial hash for next message
    input  t_word     i_blk [16],   // block words
    output t_rnd_stat o_stat,
    output t_word     o_hash [8]
);

    localparam int unsigned RW = $clog2(MaxRounds + 1);

    t_word          r_w [16];
    t_word          r_v [8];
    t_word          r_h [8];
    logic           r_busy;
    logic           r_done;
    logic           r_done_q;
    logic [RW-1:0]  r_t;

    t_word w_cur, s0, s1, t1, t2, w_new;
    logic [3:0] t4;

    // schedule word and round arithmetic
    always_comb begin
        t4    = r_t[3:0];
        s1    = rotr(r_w[t4 - 4'd2], 19) ^ rotr(r_w[t4 - 4'd2], 61) ^ (r_w[t4 - 4'd2] >> 6);
        s0    = rotr(r_w[t4 - 4'd15], 1) ^ rotr(r_w[t4 - 4'd15], 8) ^ (r_w[t4 - 4'd15] >> 7);
        w_new = s1 + r_w[t4 - 4'd7] + s0 + r_w[t4];
        w_cur = (r_t < RW'(16)) ? r_w[t4] : w_new;
        t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundConst[r_t[6:0]] + w_cur;
        t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // round sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_t    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_t    <= '0;
            r_w    <= i_blk;
            r_v    <= r_h;
        end else if (r_busy) begin
            r_w[t4] <= w_cur;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            if (r_t == RW'(ROUND_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
            r_t <= r_t + RW'(1);
        end else if (r_done) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end else if (i_init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end
    end

    // last round of the block just ran
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_busy && !i_ctrl.start && (r_t == RW'(ROUND_COUNT - 1));
    end

    // done, registered from r_done, rises together with the added-back hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done_q <= 1'b0;
        else          r_done_q <= r_done;
    end

    assign o_stat.done = r_done_q;
    assign o_hash      = r_h;

endmodule
